// ----- sv/ring_entry_buffer_offset_find_unit_macros.svh -----
// Assertion macros for the port-level checker (rebofu_checker) of the ring entry buffer.
// No dependencies; include with the bare file name.
`ifndef RING_ENTRY_BUFFER_OFFSET_FIND_UNIT_MACROS_SVH
`define RING_ENTRY_BUFFER_OFFSET_FIND_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define REBOFU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define REBOFU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rebofu_pkg.sv -----
// Package for the ring entry buffer: field widths, opcodes, request/result structs.
// No dependencies.
`default_nettype none

package rebofu_pkg;

    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;
    localparam int POS_W    = 20;
    localparam int SLOT_W   = 4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [HANDLE_W-1:0] data_handle;
        logic [LEN_W-1:0]    data_length;
        logic [POS_W-1:0]    byte_position;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] result_handle;
        logic                evicted;
        logic [LEN_W-1:0]    offset_in_entry;
        logic [SLOT_W-1:0]   slot_index;
    } rsp_t;

endpackage

`default_nettype wire

// ----- sv/rebofu_store.sv -----
// Entry store: handle and length memories, one write and one registered read port.
// Depends on rebofu_pkg (field widths). Read-first when both ports hit one entry.
`default_nettype none

module rebofu_store #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [rebofu_pkg::HANDLE_W-1:0] wr_handle,
    input  wire logic [rebofu_pkg::LEN_W-1:0]  wr_length,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [rebofu_pkg::HANDLE_W-1:0] rd_handle,
    output logic      [rebofu_pkg::LEN_W-1:0]  rd_length
);

    logic [rebofu_pkg::HANDLE_W-1:0] handle_mem [DEPTH];
    logic [rebofu_pkg::LEN_W-1:0]    length_mem [DEPTH];
    logic [rebofu_pkg::HANDLE_W-1:0] rd_handle_reg;
    logic [rebofu_pkg::LEN_W-1:0]    rd_length_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_handle_reg <= handle_mem[rd_addr];
            rd_length_reg <= length_mem[rd_addr];
        end
        if (wr_en) begin
            handle_mem[wr_addr] <= wr_handle;
            length_mem[wr_addr] <= wr_length;
        end
    end

    assign rd_handle = rd_handle_reg;
    assign rd_length = rd_length_reg;

endmodule

`default_nettype wire

// ----- sv/ring_entry_buffer_offset_find_unit.sv -----
// Ring of DEPTH entries (handle, byte length) that overwrites the oldest entry when
// full, and finds the entry holding a byte offset into the stored data, oldest
// first. One request is worked on at a time. An add goes through the ADD and DONE
// states to the result. A find reads one stored entry per cycle from the synchronous
// entry store and stops at the first hit or after the last stored entry; an empty
// ring answers without a walk. A new request is taken as soon as the previous result
// sits in the output register, even while that result is still waiting for m_ready.
// Depends on rebofu_pkg and rebofu_store.
`default_nettype none

module ring_entry_buffer_offset_find_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rebofu_pkg::req_t  s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rebofu_pkg::rsp_t       m_rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_FIND = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [rebofu_pkg::SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W+rebofu_pkg::SLOT_W-1:0] w;
        w = {{rebofu_pkg::SLOT_W{1'b0}}, p};
        return w[rebofu_pkg::SLOT_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic             full_reg;
    logic             evict_reg;
    logic [PTR_W-1:0] slot_reg;
    logic [rebofu_pkg::POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] n_reg, iss_cnt_reg, chk_cnt_reg;
    logic [PTR_W-1:0] iss_idx_reg, rsp_idx_reg;
    logic             rsp_vld_reg;
    rebofu_pkg::rsp_t res_reg, out_reg;
    logic             out_vld_reg;

    logic             accept, is_add, empty, issue, hit_now, last_chk, load_out;
    logic [PTR_W-1:0] wp_inc;
    logic [CNT_W-1:0] n_now;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [rebofu_pkg::HANDLE_W-1:0] rd_handle;
    logic [rebofu_pkg::LEN_W-1:0]    rd_length;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_add   = (s_req.opcode == rebofu_pkg::OP_ADD);
    assign empty    = (wp_reg == rp_reg) && !full_reg;
    assign wp_inc   = next_ptr(wp_reg);
    assign issue    = (state_reg == ST_FIND) && (iss_cnt_reg < n_reg);
    assign hit_now  = rsp_vld_reg &&
                      (pos_reg < {{(rebofu_pkg::POS_W-rebofu_pkg::LEN_W){1'b0}}, rd_length});
    assign last_chk = (chk_cnt_reg + 1'b1) == n_reg;
    assign load_out = (state_reg == ST_DONE) && (!out_vld_reg || m_ready);

    always_comb begin
        if (full_reg) begin
            n_now = DEPTH_CNT;
        end else if (wp_reg >= rp_reg) begin
            n_now = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            n_now = {1'b0, wp_reg} + DEPTH_CNT - {1'b0, rp_reg};
        end
    end

    assign rd_en   = accept || issue;
    assign rd_addr = (state_reg == ST_FIND) ? iss_idx_reg : rp_reg;

    rebofu_store #(.DEPTH(DEPTH)) u_store (
        .aclk      (aclk),
        .wr_en     (accept && is_add),
        .wr_addr   (wp_reg),
        .wr_handle (s_req.data_handle),
        .wr_length (s_req.data_length),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_handle (rd_handle),
        .rd_length (rd_length)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_add) begin
                        state_next = ST_ADD;
                    end else if (empty) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_ADD:  state_next = ST_DONE;
            ST_FIND: begin
                if (rsp_vld_reg && (hit_now || last_chk)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            full_reg    <= 1'b0;
            rsp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && is_add) begin
                wp_reg   <= wp_inc;
                full_reg <= full_reg || (wp_inc == rp_reg);
                if (full_reg) begin
                    rp_reg <= next_ptr(rp_reg);
                end
            end
            if (accept) begin
                rsp_vld_reg <= !is_add && !empty;
            end else if (state_reg == ST_FIND) begin
                rsp_vld_reg <= issue;
            end else begin
                rsp_vld_reg <= 1'b0;
            end
            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // request and walk datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            evict_reg   <= full_reg;
            slot_reg    <= wp_reg;
            pos_reg     <= s_req.byte_position;
            n_reg       <= n_now;
            chk_cnt_reg <= '0;
            iss_idx_reg <= next_ptr(rp_reg);
            iss_cnt_reg <= CNT_W'(1);
            rsp_idx_reg <= rp_reg;
            if (!is_add && empty) begin
                res_reg <= '0;
            end
        end
        if (issue) begin
            iss_idx_reg <= next_ptr(iss_idx_reg);
            iss_cnt_reg <= iss_cnt_reg + 1'b1;
            rsp_idx_reg <= iss_idx_reg;
        end
        if (state_reg == ST_ADD) begin
            res_reg.hit             <= 1'b0;
            res_reg.result_handle   <= evict_reg ? rd_handle : '0;
            res_reg.evicted         <= evict_reg;
            res_reg.offset_in_entry <= '0;
            res_reg.slot_index      <= slot_of(slot_reg);
        end
        if (state_reg == ST_FIND && rsp_vld_reg) begin
            if (hit_now) begin
                res_reg.hit             <= 1'b1;
                res_reg.result_handle   <= rd_handle;
                res_reg.evicted         <= 1'b0;
                res_reg.offset_in_entry <= pos_reg[rebofu_pkg::LEN_W-1:0];
                res_reg.slot_index      <= slot_of(rsp_idx_reg);
            end else begin
                pos_reg     <= pos_reg - {{(rebofu_pkg::POS_W-rebofu_pkg::LEN_W){1'b0}},
                                          rd_length};
                chk_cnt_reg <= chk_cnt_reg + 1'b1;
                if (last_chk) begin
                    res_reg <= '0;
                end
            end
        end
        if (load_out) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_rsp   = out_reg;

endmodule

`default_nettype wire

// ----- sv/rebofu_checker.sv -----
// Port-level checks for ring_entry_buffer_offset_find_unit, bound to the top level.
// Depends on rebofu_pkg and ring_entry_buffer_offset_find_unit_macros.svh.
`default_nettype none
`include "ring_entry_buffer_offset_find_unit_macros.svh"

module rebofu_checker (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire rebofu_pkg::req_t s_req,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire rebofu_pkg::rsp_t m_rsp
);

    `REBOFU_ASSERT_ALWAYS(a_reset_clears_result, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `REBOFU_ASSERT(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)), "stalled result changed")
    `REBOFU_ASSERT(a_one_request_at_a_time, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "request taken while busy")
    `REBOFU_ASSERT(a_hit_excludes_evict, aclk, aresetn, m_valid |-> !(m_rsp.hit && m_rsp.evicted), "hit and evicted both set")
    `REBOFU_ASSERT(a_miss_zero_offset, aclk, aresetn, (m_valid && !m_rsp.hit) |-> (m_rsp.offset_in_entry == '0), "nonzero offset without hit")

endmodule

bind ring_entry_buffer_offset_find_unit rebofu_checker u_rebofu_checker (.*);

`default_nettype wire

// ----- tb/ring_entry_buffer_offset_find_unit_checker.sv -----
// Checker for the ring entry buffer: watches both channels, predicts each result
// from its own copy of the ring, and compares. Depends on rebofu_pkg.
module ring_entry_buffer_offset_find_unit_checker #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  rebofu_pkg::req_t    s_req,
    input  logic                m_valid,
    input  logic                m_ready,
    input  rebofu_pkg::rsp_t    m_rsp,
    output int unsigned         mismatches,
    output int unsigned         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANDLE_W = rebofu_pkg::HANDLE_W;
    localparam int LEN_W    = rebofu_pkg::LEN_W;
    localparam int SLOT_W   = rebofu_pkg::SLOT_W;

    logic [HANDLE_W-1:0] handle_ring [DEPTH];
    logic [LEN_W-1:0]    length_ring [DEPTH];
    int unsigned         wr_idx;
    int unsigned         rd_idx;
    bit                  ring_full;
    rebofu_pkg::rsp_t    expected_rsps [$];

    // Applies one request to the ring copy and returns the result it must produce.
    function automatic rebofu_pkg::rsp_t ring_response(rebofu_pkg::req_t r);
        rebofu_pkg::rsp_t rsp;
        int unsigned remaining;
        int unsigned idx;
        bit          done;
        rsp = '0;
        if (r.opcode == rebofu_pkg::OP_ADD) begin
            if (ring_full) begin
                rsp.result_handle = handle_ring[rd_idx];
                rsp.evicted = 1'b1;
                rd_idx = (rd_idx + 1) % DEPTH;
            end
            handle_ring[wr_idx] = r.data_handle;
            length_ring[wr_idx] = r.data_length;
            rsp.slot_index = SLOT_W'(wr_idx);
            wr_idx = (wr_idx + 1) % DEPTH;
            if (wr_idx == rd_idx) ring_full = 1'b1;
        end else if (ring_full || wr_idx != rd_idx) begin
            remaining = r.byte_position;
            idx = rd_idx;
            done = 1'b0;
            for (int n = 0; n < DEPTH && !done; n++) begin
                if (!ring_full && idx == wr_idx) begin
                    done = 1'b1;
                end else if (remaining < length_ring[idx]) begin
                    rsp.hit = 1'b1;
                    rsp.result_handle = handle_ring[idx];
                    rsp.offset_in_entry = LEN_W'(remaining);
                    rsp.slot_index = SLOT_W'(idx);
                    done = 1'b1;
                end else begin
                    remaining = remaining - length_ring[idx];
                    idx = (idx + 1) % DEPTH;
                end
            end
        end
        return rsp;
    endfunction

    always @(posedge aclk) begin
        rebofu_pkg::rsp_t exp_rsp;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                handle_ring[i] = '0;
                length_ring[i] = '0;
            end
            wr_idx = 0;
            rd_idx = 0;
            ring_full = 1'b0;
            expected_rsps.delete();
            mismatches <= 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_rsps.push_back(ring_response(s_req));
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with no request outstanding: %p", $time, m_rsp);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (m_rsp.hit !== exp_rsp.hit
                            || m_rsp.result_handle !== exp_rsp.result_handle
                            || m_rsp.evicted !== exp_rsp.evicted
                            || m_rsp.offset_in_entry !== exp_rsp.offset_in_entry
                            || m_rsp.slot_index !== exp_rsp.slot_index) begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch: expected %p, got %p",
                                     $time, exp_rsp, m_rsp);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= expected_rsps.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the ring entry buffer testbench: clock, reset, request and result drivers,
// verdict. Depends on rebofu_pkg, the block and its checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int RANDOM_REQS = 800;
    localparam int LONG_HOLD = 400;
    localparam int HANDLE_W = rebofu_pkg::HANDLE_W;
    localparam int LEN_W    = rebofu_pkg::LEN_W;
    localparam int POS_W    = rebofu_pkg::POS_W;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    rebofu_pkg::req_t s_req = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    rebofu_pkg::rsp_t m_rsp;
    int unsigned      mismatches;
    int unsigned      pending;
    bit               calm = 1'b0;
    bit               long_hold_req = 1'b0;

    always #5 aclk = ~aclk;

    ring_entry_buffer_offset_find_unit #(.DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    ring_entry_buffer_offset_find_unit_checker #(.DEPTH(DEPTH)) ring_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic rebofu_pkg::req_t add_req(logic [HANDLE_W-1:0] h,
                                                 logic [LEN_W-1:0] len);
        rebofu_pkg::req_t r;
        r = '0;
        r.opcode = rebofu_pkg::OP_ADD;
        r.data_handle = h;
        r.data_length = len;
        return r;
    endfunction

    function automatic rebofu_pkg::req_t find_req(logic [POS_W-1:0] pos);
        rebofu_pkg::req_t r;
        r = '0;
        r.opcode = rebofu_pkg::OP_FIND;
        r.byte_position = pos;
        return r;
    endfunction

    // Unused fields stay random so every bit toggles.
    function automatic rebofu_pkg::req_t random_req();
        rebofu_pkg::req_t r;
        int unsigned      pick;
        r.data_handle = $urandom;
        r.data_length = LEN_W'($urandom);
        r.byte_position = POS_W'($urandom);
        r.opcode = ($urandom_range(0, 99) < 45) ? rebofu_pkg::OP_ADD : rebofu_pkg::OP_FIND;
        pick = $urandom_range(0, 99);
        if (r.opcode == rebofu_pkg::OP_ADD) begin
            if (pick < 10) r.data_length = '0;
            else if (pick < 60) r.data_length = LEN_W'($urandom_range(1, 255));
            else if (pick < 85) r.data_length = LEN_W'($urandom_range(256, 8191));
        end else begin
            if (pick < 60) r.byte_position = POS_W'($urandom_range(0, 3000));
            else if (pick < 80) r.byte_position = POS_W'($urandom_range(0, 40000));
        end
        return r;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(rebofu_pkg::req_t r, int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int unsigned run;
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                run = $urandom_range(1, 12);
                m_ready <= 1'b1;
                repeat (run) @(negedge aclk);
                stall = idle_len();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty ring, extremes, zero-length step-over, end of data, eviction
        send_req(find_req('0), idle_len());
        send_req(find_req('1), idle_len());
        send_req(add_req('0, '0), idle_len());
        send_req(add_req('1, '1), idle_len());
        send_req(add_req(32'hA5A5_5A5A, 16'd1), idle_len());
        send_req(find_req(20'd0), idle_len());
        send_req(find_req(20'd65534), idle_len());
        send_req(find_req(20'd65535), idle_len());
        send_req(find_req(20'd65536), idle_len());
        send_req(find_req('1), idle_len());
        for (int i = 3; i < DEPTH; i++)
            send_req(add_req(HANDLE_W'(i * 32'h0101_0101), LEN_W'(i * 16)), idle_len());
        send_req(add_req(32'h1234_5678, 16'd100), idle_len());
        send_req(find_req(20'd0), idle_len());
        send_req(find_req(20'd65700), idle_len());

        for (int i = 0; i < RANDOM_REQS; i++) begin
            calm = ((i / 100) % 4) == 2;
            if (i == 200) long_hold_req = 1'b1;
            if (i == 500) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
            end
            send_req(random_req(), (i == 500) ? 0 : idle_len());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DEPTH + 8) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS ring_entry_buffer_offset_find_unit");
        end else begin
            $display("FAIL ring_entry_buffer_offset_find_unit");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL ring_entry_buffer_offset_find_unit");
        $finish;
    end

endmodule

// ----- ring_entry_buffer_offset_find_unit.f -----
+incdir+sv
sv/rebofu_pkg.sv
sv/rebofu_store.sv
sv/ring_entry_buffer_offset_find_unit.sv
sv/rebofu_checker.sv
tb/ring_entry_buffer_offset_find_unit_checker.sv
tb/tb.sv
